// ===== hdl/aewd_pkg.sv =====
// shared types and constants for the adc event word demultiplexer
`default_nettype none

package aewd_pkg;

  // fixed field widths of the readout word and results
  localparam int WORD_W = 32;
  localparam int CHAN_W = 5;
  localparam int VAL_W  = 12;
  localparam int TYPE_W = 3;

  // word layout
  localparam int TYPE_LSB = 24;
  localparam int CHAN_LSB = 16;
  localparam int OVER_BIT = 12;

  // word type codes
  localparam logic [TYPE_W-1:0] TYPE_DATA   = 3'h0;
  localparam logic [TYPE_W-1:0] TYPE_HEADER = 3'h2;
  localparam logic [TYPE_W-1:0] TYPE_END    = 3'h4;

  // configuration register file
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int CCOUNT_W = 6;
  localparam int VBITS_W  = 4;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT  = 2'd0,
    REG_VALUE_BITS     = 2'd1,
    REG_CHANNEL_ENABLE = 2'd2
  } reg_idx_t;

  localparam logic [CCOUNT_W-1:0] CCOUNT_RST = 6'd32;
  localparam logic [VBITS_W-1:0]  VBITS_RST  = 4'd12;
  localparam logic [DATA_W-1:0]   ENABLE_RST = 32'h0;

  // parameter defaults
  localparam int MAX_CHANNELS_DEF = 32;
  localparam int VALUE_WIDTH_DEF  = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_t;

  typedef struct packed {
    logic open_event;
    logic keep;
    logic close;
    logic scan_read;
    logic idx_inc;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_header;
    logic is_data;
    logic is_end;
    logic keep_ok;
    logic pending_empty;
    logic pending_at_idx;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/adc_event_word_demux_core.sv =====
// top level of the adc event word demultiplexer
// Ordinary readout words (header, data, others) are taken one per clock cycle.
// An end-of-block word that closes an event holds off input while the kept
// values are emitted: the controller walks the channel indices one per cycle
// up to the highest one still to be sent, does a registered read of the value
// store for each emitted value and waits while the output is stalled, then
// finds nothing left and opens the input again. The output register lets a
// new word be accepted while the final result of an event still waits to be
// taken.
`default_nettype none

module adc_event_word_demux_core
  import aewd_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAN_W-1:0]      out_channel,
  output logic [VAL_W-1:0]       out_value,
  output logic                   out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  aewd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  aewd_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .out_value   (out_value),
    .out_last    (out_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

`default_nettype wire

// ===== hdl/aewd_ctrl.sv =====
// controller: event tracking and emission sequencing
`default_nettype none

module aewd_ctrl
  import aewd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   in_event_r, in_event_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_event_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_event_r <= in_event_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_event_nxt = in_event_r;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (status.is_header && !in_event_r) begin
            in_event_nxt   = 1'b1;
            cmd.open_event = 1'b1;
          end else if (status.is_data && in_event_r && status.keep_ok) begin
            cmd.keep = 1'b1;
          end else if (status.is_end && in_event_r) begin
            in_event_nxt = 1'b0;
            cmd.close    = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.pending_empty) begin
          state_nxt = ST_IDLE;
        end else if (status.pending_at_idx) begin
          cmd.scan_read = 1'b1;
          state_nxt     = ST_READ;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_READ: begin
        // wait for room in the output register
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/aewd_datapath.sv =====
// datapath: config registers, value store, seen bits, channel walk and output register
`default_nettype none

module aewd_datapath
  import aewd_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [WORD_W-1:0] in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAN_W-1:0]      out_channel,
  output logic [VAL_W-1:0]       out_value,
  output logic                   out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             status
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [VAL_W-1:0] VALUE_MASK =
    (VALUE_WIDTH >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((1 << VALUE_WIDTH) - 1);

  // configuration
  logic [CCOUNT_W-1:0] channel_count_r;
  logic [VBITS_W-1:0]  value_bits_r;
  logic [DATA_W-1:0]   channel_enable_r;
  logic                cfg_wr;
  reg_idx_t            reg_sel;

  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r  <= CCOUNT_RST;
      value_bits_r     <= VBITS_RST;
      channel_enable_r <= ENABLE_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CHANNEL_COUNT:  channel_count_r  <= pwdata[CCOUNT_W-1:0];
        REG_VALUE_BITS:     value_bits_r     <= pwdata[VBITS_W-1:0];
        REG_CHANNEL_ENABLE: channel_enable_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CHANNEL_COUNT:  prdata = DATA_W'(channel_count_r);
      REG_VALUE_BITS:     prdata = DATA_W'(value_bits_r);
      REG_CHANNEL_ENABLE: prdata = channel_enable_r;
      default:            prdata = '0;
    endcase
  end

  // word decode
  logic [TYPE_W-1:0] w_type;
  logic [CHAN_W-1:0] w_chan;
  logic [VAL_W-1:0]  w_val;
  logic              w_over;
  logic [IDX_W-1:0]  w_idx;
  logic              chan_ok;
  logic              val_ok;
  logic              decode_on;
  logic              seen_at_chan;

  logic [MAX_CHANNELS-1:0] seen_r;
  logic [MAX_CHANNELS-1:0] pending_r;
  logic [MAX_CHANNELS-1:0] pending_nxt;
  logic [IDX_W-1:0]        idx_r;
  logic [VAL_W-1:0]        val_mem [MAX_CHANNELS];
  logic [VAL_W-1:0]        rdata_r;

  assign w_type    = in_word[TYPE_LSB +: TYPE_W];
  assign w_chan    = in_word[CHAN_LSB +: CHAN_W];
  assign w_val     = in_word[VAL_W-1:0];
  assign w_over    = in_word[OVER_BIT];
  assign w_idx     = w_chan[IDX_W-1:0];
  assign decode_on = |channel_enable_r;
  assign chan_ok   = ({1'b0, w_chan} < channel_count_r)
                   && ({1'b0, w_chan} < CCOUNT_W'(MAX_CHANNELS));
  assign val_ok    = (16'(w_val) < (16'd1 << value_bits_r)) && !w_over;
  assign seen_at_chan = chan_ok ? seen_r[w_idx] : 1'b1;

  assign status.is_header = (w_type == TYPE_HEADER);
  assign status.is_data   = (w_type == TYPE_DATA);
  assign status.is_end    = (w_type == TYPE_END);
  assign status.keep_ok   = decode_on && chan_ok && val_ok && !seen_at_chan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (cmd.open_event) begin
      seen_r <= '0;
    end else if (cmd.keep) begin
      seen_r[w_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.keep) begin
      val_mem[w_idx] <= w_val;
    end
    if (cmd.scan_read) begin
      rdata_r <= val_mem[idx_r];
    end
  end

  // channels still to be emitted for the closing event
  always_comb begin
    pending_nxt = pending_r;
    if (cmd.close) begin
      pending_nxt = decode_on ? (seen_r & channel_enable_r[MAX_CHANNELS-1:0]) : '0;
    end else if (cmd.scan_read) begin
      pending_nxt[idx_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      idx_r     <= '0;
    end else begin
      pending_r <= pending_nxt;
      if (cmd.close) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign status.pending_empty  = ~|pending_r;
  assign status.pending_at_idx = ({1'b0, idx_r} < (IDX_W+1)'(MAX_CHANNELS))
                               && pending_r[idx_r];

  // output register
  logic out_valid_r;
  logic out_valid_nxt;
  logic [CHAN_W-1:0] out_channel_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_last_r;

  assign status.out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel_r <= CHAN_W'(idx_r);
      out_value_r   <= rdata_r & VALUE_MASK;
      out_last_r    <= ~|pending_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_value   = out_value_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/aewd_checker.sv =====
// port-level checker for the adc event word demultiplexer, with its bind
`default_nettype none

module aewd_checker
  import aewd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [CHAN_W-1:0] out_channel,
  input wire logic [VAL_W-1:0]  out_value,
  input wire logic              out_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel)
      && $stable(out_value) && $stable(out_last))
    else $error("result word changed while stalled");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // new results only appear while an event is being emitted
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("result appeared while input was open");

  // input is only held off after a word was taken
  a_stall_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stalled without an accepted word");

endmodule

bind adc_event_word_demux_core aewd_checker u_aewd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_channel (out_channel),
  .out_value   (out_value),
  .out_last    (out_last)
);

`default_nettype wire

// ===== verif/tb_adc_event_word_demux_core.sv =====
// self-checking testbench for the adc event word demultiplexer core
`timescale 1ns / 100ps

module tb_adc_event_word_demux_core;
  import aewd_pkg::*;

  // word types the block has no action for
  localparam logic [TYPE_W-1:0] TYPE_SPARE1  = 3'h1;
  localparam logic [TYPE_W-1:0] TYPE_SPARE3  = 3'h3;
  localparam logic [TYPE_W-1:0] TYPE_SPARE5  = 3'h5;
  localparam logic [TYPE_W-1:0] TYPE_INVALID = 3'h6;
  localparam logic [TYPE_W-1:0] TYPE_SPARE7  = 3'h7;
  localparam logic [TYPE_W-1:0] IGNORED_TYPES [5] =
    '{TYPE_SPARE1, TYPE_SPARE3, TYPE_SPARE5, TYPE_INVALID, TYPE_SPARE7};

  localparam int NUM_CH       = 32;
  localparam int ROUND_WORDS  = 24;
  localparam int DRAIN_CYCLES = 2 * NUM_CH + 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  value;
    logic              last;
  } chan_value_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [WORD_W-1:0] in_word = '0;
  logic              out_stall = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic              in_stall;
  logic              out_valid;
  logic [CHAN_W-1:0] out_channel;
  logic [VAL_W-1:0]  out_value;
  logic              out_last;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // mirror of the block state and its registers
  logic              ev_open = 1'b0;
  logic [VAL_W-1:0]  kept_val [NUM_CH];
  logic [NUM_CH-1:0] kept_seen = '0;
  logic [CCOUNT_W-1:0] cfg_count = CCOUNT_RST;
  logic [VBITS_W-1:0]  cfg_bits = VBITS_RST;
  logic [DATA_W-1:0]   cfg_enable = ENABLE_RST;

  chan_value_t pending_values[$];
  chan_value_t want;

  bit send_gaps_on  = 1'b0;
  bit stall_gaps_on = 1'b0;
  int hold_len = 0;

  int err_count = 0;
  int decoded_words = 0;
  int events_closed = 0;
  int values_checked = 0;
  int stall_cycles = 0;

  adc_event_word_demux_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_channel(out_channel),
    .out_value  (out_value),
    .out_last   (out_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // works out the channel values a word releases and queues them
  function automatic void decode_word(logic [WORD_W-1:0] w);
    logic [CHAN_W-1:0] ch;
    logic [VAL_W-1:0]  v;
    int hi;
    chan_value_t cv;
    ch = w[CHAN_LSB +: CHAN_W];
    v  = w[VAL_W-1:0];
    case (w[TYPE_LSB +: TYPE_W])
      TYPE_HEADER: begin
        if (!ev_open) begin
          ev_open = 1'b1;
          kept_seen = '0;
          decoded_words++;
        end
      end
      TYPE_DATA: begin
        if (ev_open) begin
          decoded_words++;
          if (cfg_enable != '0 && int'(ch) < int'(cfg_count) && !w[OVER_BIT] &&
              int'(v) < (1 << cfg_bits) && !kept_seen[ch]) begin
            kept_seen[ch] = 1'b1;
            kept_val[ch] = v;
          end
        end
      end
      TYPE_END: begin
        if (ev_open) begin
          ev_open = 1'b0;
          decoded_words++;
          events_closed++;
          hi = -1;
          if (cfg_enable != '0) begin
            for (int c = 0; c < NUM_CH; c++) begin
              if (kept_seen[c] && cfg_enable[c]) hi = c;
            end
          end
          for (int c = 0; c <= hi; c++) begin
            if (kept_seen[c] && cfg_enable[c]) begin
              cv.channel = c[CHAN_W-1:0];
              cv.value = kept_val[c];
              cv.last = (c == hi);
              pending_values.push_back(cv);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] make_word(logic [TYPE_W-1:0] t, logic [CHAN_W-1:0] ch,
                                                  logic over, logic [VAL_W-1:0] v);
    logic [WORD_W-1:0] w;
    w = $urandom;
    w[TYPE_LSB +: TYPE_W] = t;
    w[CHAN_LSB +: CHAN_W] = ch;
    w[OVER_BIT] = over;
    w[VAL_W-1:0] = v;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] random_data_word();
    int top;
    int vmax;
    logic [CHAN_W-1:0] ch;
    logic [VAL_W-1:0] v;
    top = (cfg_count == 0 || cfg_count > NUM_CH) ? NUM_CH - 1 : int'(cfg_count) - 1;
    ch = CHAN_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, NUM_CH - 1)
                                              : $urandom_range(0, top));
    vmax = (cfg_bits >= VAL_W) ? (1 << VAL_W) - 1 : (1 << cfg_bits) - 1;
    case ($urandom_range(0, 9))
      0: v = VAL_W'($urandom_range(0, (1 << VAL_W) - 1));
      1: v = VAL_W'(vmax);
      default: v = VAL_W'($urandom_range(0, vmax));
    endcase
    return make_word(TYPE_DATA, ch, $urandom_range(0, 19) == 0, v);
  endfunction

  function automatic logic [WORD_W-1:0] noise_word();
    case ($urandom_range(0, 3))
      0: return make_word(IGNORED_TYPES[$urandom_range(0, 4)], CHAN_W'($urandom),
                          1'($urandom), VAL_W'($urandom));
      1: return $urandom;
      2: return make_word(TYPE_HEADER, CHAN_W'($urandom), 1'($urandom), VAL_W'($urandom));
      default: return make_word(TYPE_END, CHAN_W'($urandom), 1'($urandom), VAL_W'($urandom));
    endcase
  endfunction

  // entered and left at a rising edge; valid stays high into the next word
  task automatic send_word(logic [WORD_W-1:0] w);
    if (send_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(w);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT:  cfg_count = data[CCOUNT_W-1:0];
      REG_VALUE_BITS:     cfg_bits = data[VBITS_W-1:0];
      REG_CHANNEL_ENABLE: cfg_enable = data;
      default: ;
    endcase
  endtask

  // wait for the output to drain, then allow for a trailing channel scan
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0 || hold_len != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(int count, int bits, logic [DATA_W-1:0] enable);
    settle();
    cfg_write(REG_CHANNEL_COUNT, count);
    cfg_write(REG_VALUE_BITS, bits);
    cfg_write(REG_CHANNEL_ENABLE, enable);
  endtask

  task automatic send_random_event(int max_words);
    int n;
    if ($urandom_range(0, 9) == 0) send_word(noise_word());
    send_word(make_word(TYPE_HEADER, CHAN_W'($urandom), 1'($urandom), VAL_W'($urandom)));
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, max_words) : $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 11) == 0) send_word(noise_word());
      else send_word(random_data_word());
    end
    // now and then the end of block goes missing
    if ($urandom_range(0, 19) != 0)
      send_word(make_word(TYPE_END, CHAN_W'($urandom), 1'($urandom), VAL_W'($urandom)));
  endtask

  task automatic run_round(int count, int bits, logic [DATA_W-1:0] enable);
    int start;
    apply_settings(count, bits, enable);
    start = decoded_words;
    while (decoded_words - start < ROUND_WORDS) send_random_event(40);
  endtask

  // decoding is off after reset, so nothing comes out
  task automatic test_decode_disabled();
    send_word(make_word(TYPE_HEADER, 5'd0, 1'b0, 12'd0));
    send_word(make_word(TYPE_DATA, 5'd2, 1'b0, 12'd9));
    send_word(make_word(TYPE_END, 5'd0, 1'b0, 12'd0));
  endtask

  task automatic test_word_sequencing();
    apply_settings(NUM_CH, VAL_W, '1);
    send_word(make_word(TYPE_END, 5'd1, 1'b0, 12'd1));
    send_word(make_word(TYPE_DATA, 5'd1, 1'b0, 12'd1));
    send_word(make_word(TYPE_HEADER, 5'd0, 1'b0, 12'd0));
    send_word(make_word(TYPE_DATA, 5'd5, 1'b0, 12'h123));
    // second header inside the event must not clear channel 5
    send_word(make_word(TYPE_HEADER, 5'd0, 1'b0, 12'd0));
    send_word(make_word(TYPE_DATA, 5'd0, 1'b0, 12'hfff));
    send_word(make_word(TYPE_DATA, 5'd31, 1'b0, 12'h000));
    send_word(make_word(TYPE_DATA, 5'd5, 1'b0, 12'h007));
    send_word(make_word(TYPE_DATA, 5'd7, 1'b1, 12'h000));
    foreach (IGNORED_TYPES[i]) send_word(make_word(IGNORED_TYPES[i], 5'd9, 1'b0, 12'd1));
    send_word(make_word(TYPE_DATA, 5'd9, 1'b0, 12'habc));
    send_word(make_word(TYPE_END, 5'd0, 1'b0, 12'd0));
  endtask

  // enable taken at end of block, not when the value arrived
  task automatic test_enable_mid_event();
    send_word(make_word(TYPE_HEADER, 5'd0, 1'b0, 12'd0));
    send_word(make_word(TYPE_DATA, 5'd0, 1'b0, 12'd17));
    send_word(make_word(TYPE_DATA, 5'd10, 1'b0, 12'd300));
    send_word(make_word(TYPE_DATA, 5'd31, 1'b0, 12'd4000));
    settle();
    cfg_write(REG_CHANNEL_ENABLE, 32'h0000_0400);
    send_word(make_word(TYPE_END, 5'd0, 1'b0, 12'd0));
  endtask

  task automatic test_random_settings();
    send_gaps_on = 1'b1;
    stall_gaps_on = 1'b1;
    run_round(NUM_CH, VAL_W, '1);
    run_round(1, VAL_W, $urandom);
    run_round(0, VAL_W, '1);
    run_round(63, 0, '1);
    run_round($urandom_range(1, NUM_CH), 1, $urandom);
    run_round($urandom_range(1, NUM_CH), 15, $urandom);
    run_round($urandom_range(0, 63), $urandom_range(1, VAL_W), '0);
  endtask

  // output held off for a long time while full events keep coming
  task automatic test_output_backpressure();
    int order [NUM_CH];
    int j;
    int t;
    send_gaps_on = 1'b0;
    stall_gaps_on = 1'b0;
    apply_settings(NUM_CH, VAL_W, '1);
    hold_len = 300;
    repeat (3) begin
      foreach (order[i]) order[i] = i;
      for (int i = NUM_CH - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      send_word(make_word(TYPE_HEADER, 5'd0, 1'b0, 12'd0));
      foreach (order[i])
        send_word(make_word(TYPE_DATA, CHAN_W'(order[i]), 1'b0, VAL_W'($urandom)));
      send_word(make_word(TYPE_END, 5'd0, 1'b0, 12'd0));
    end
  endtask

  task automatic test_steady_stream();
    send_gaps_on = 1'b0;
    stall_gaps_on = 1'b0;
    run_round(NUM_CH, VAL_W, $urandom);
  endtask

  always begin
    @(posedge clk);
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_len = 0;
      out_stall <= 1'b0;
    end else if (stall_gaps_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(string what, chan_value_t exp_cv);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s: expected ch %0d value %0d last %0b, got ch %0d value %0d last %0b",
               $realtime, what, exp_cv.channel, exp_cv.value, exp_cv.last,
               out_channel, out_value, out_last);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      values_checked++;
      if (pending_values.size() == 0) begin
        report_mismatch("word with nothing expected", '0);
      end else begin
        want = pending_values.pop_front();
        if (out_channel !== want.channel || out_value !== want.value || out_last !== want.last)
          report_mismatch("wrong channel value", want);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("timed out with %0d values still expected", pending_values.size());
    $display("FAIL adc_event_word_demux_core");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_decode_disabled();
    test_word_sequencing();
    test_enable_mid_event();
    test_random_settings();
    test_output_backpressure();
    test_steady_stream();
    settle();
    err_count += pending_values.size();
    $display("decoded %0d words, %0d events closed, count/resolution/enable extremes swept",
             decoded_words, events_closed);
    $display("%0d channel values checked, input held off %0d cycles, %0d errors",
             values_checked, stall_cycles, err_count);
    if (err_count == 0) begin
      $display("PASS adc_event_word_demux_core");
    end else begin
      $display("FAIL adc_event_word_demux_core");
    end
    $finish;
  end

endmodule
